// ===== rtl/core/ddd_stream_decoder_top_defines.svh =====
// assertion macros for the stream decoder
`ifndef DDD_STREAM_DECODER_TOP_DEFINES_SVH
`define DDD_STREAM_DECODER_TOP_DEFINES_SVH

// condition holds in the same cycle
`define DDD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("stream decoder check failed");

// condition holds in the next cycle
`define DDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("stream decoder check failed");

`endif

// ===== rtl/core/ddd_pkg.sv =====
// types, constants and helpers shared by the stream decoder
package ddd_pkg;

	localparam int TRACK_BYTES = 4096;
	localparam int TRACK_COUNT = 35;
	localparam int FAV_COUNT   = 20;
	localparam int FILL_W      = $clog2(TRACK_BYTES + 1);
	localparam int FAV_IDX_W   = $clog2(FAV_COUNT);

	localparam logic [1:0] KIND_VOLUME  = 2'd0;
	localparam logic [1:0] KIND_RUN     = 2'd1;
	localparam logic [1:0] KIND_HDR_ERR = 2'd2;
	localparam logic [1:0] KIND_OVERRUN = 2'd3;

	// prefix code of each favourite and the code length counted with its flag
	localparam logic [7:0] PREFIX_CODE [FAV_COUNT] = '{
		8'h04, 8'h01, 8'h0f, 8'h0e, 8'h0c, 8'h0b, 8'h0a, 8'h06, 8'h05, 8'h1b,
		8'h0f, 8'h09, 8'h08, 8'h03, 8'h02, 8'h01, 8'h00, 8'h35, 8'h1d, 8'h1c
	};
	localparam logic [3:0] PREFIX_TAKEN [FAV_COUNT] = '{
		4'd4, 4'd4, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd5, 4'd6,
		4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd7, 4'd7
	};

	typedef enum logic [6:0] {
		PH_HDR    = 7'b0000001,
		PH_FAVS   = 7'b0000010,
		PH_SYM    = 7'b0000100,
		PH_LIT    = 7'b0001000,
		PH_RCHAR  = 7'b0010000,
		PH_RCOUNT = 7'b0100000,
		PH_HALT   = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first;
	} in_t;

	typedef struct packed {
		logic [1:0] out_kind;
		logic [7:0] out_value;
		logic [8:0] out_count;
		logic [5:0] out_track;
		logic       out_end_of_track;
		logic       out_last;
	} res_t;

	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7 - i];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/ddd_front.sv =====
// input side: takes bytes and queues them for the decoder
module ddd_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  ddd_pkg::in_t item,
	output logic         avail,
	output ddd_pkg::in_t head,
	input  logic         take
);
	import ddd_pkg::*;

	in_t        mem_q [4];
	logic [1:0] wp_q;
	logic [1:0] rp_q;
	logic [2:0] cnt_q;
	logic       wr;
	logic       rd;

	assign full  = (cnt_q == 3'd4);
	assign avail = (cnt_q != 3'd0);
	assign head  = mem_q[rp_q];
	assign wr    = push && !full;
	assign rd    = take && avail;

	// storage
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 2'd1;
			end
			if (rd) begin
				rp_q <= rp_q + 2'd1;
			end
			cnt_q <= cnt_q + {2'b0, wr} - {2'b0, rd};
		end
	end

endmodule

// ===== rtl/core/ddd_back.sv =====
// back side: bit-serial code decoder and result queue
module ddd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          avail,
	input  ddd_pkg::in_t  head,
	output logic          take,
	output logic          empty,
	output ddd_pkg::res_t result,
	input  logic          pop
);
	import ddd_pkg::*;

	// bit walker
	logic       busy_q;
	logic       flush_q;
	logic [7:0] sh_q;
	logic [2:0] bit_q;

	// decoder state
	phase_t               ph_q, ph_n;
	logic [7:0]           cv_q, cv_n;
	logic [3:0]           tk_q, tk_n;
	logic [FAV_IDX_W-1:0] fi_q, fi_n;
	logic [7:0]           rc_q, rc_n;
	logic [FILL_W-1:0]    fill_q, fill_n;
	logic [5:0]           trk_q, trk_n;
	logic [7:0]           fav_q [FAV_COUNT];

	res_t pend_q;
	logic pend_v_q;

	logic                 b;
	logic [7:0]           cv_sh;
	logic [3:0]           tk_inc;
	logic                 hit;
	logic [FAV_IDX_W-1:0] hit_idx;
	logic                 fav_we;
	logic [7:0]           fav_wd;
	logic                 run_v;
	logic [7:0]           run_val;
	logic [8:0]           run_cnt;
	logic [FILL_W:0]      sum;
	logic [6:0]           trk_inc;
	logic                 res_v;
	res_t                 res;
	logic                 of_full;
	logic                 step_en;
	logic                 step_done;
	logic                 load;

	// result queue
	res_t       of_mem_q [4];
	logic [1:0] of_wp_q;
	logic [1:0] of_rp_q;
	logic [2:0] of_cnt_q;
	logic       of_push;
	res_t       of_data;
	logic       of_pop;

	assign b       = sh_q[7];
	assign cv_sh   = {cv_q[6:0], b};
	assign tk_inc  = tk_q + 4'd1;
	assign trk_inc = {1'b0, trk_q} + 7'd1;
	assign of_full = (of_cnt_q == 3'd4);
	assign step_en = busy_q && !flush_q && !of_full;
	assign load    = !busy_q && !flush_q && avail;
	assign take    = load;

	// favourite prefix match, lowest index wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < FAV_COUNT; i++) begin
			if (!hit && tk_inc == PREFIX_TAKEN[i] && cv_sh == PREFIX_CODE[i]) begin
				hit     = 1'b1;
				hit_idx = FAV_IDX_W'(i);
			end
		end
	end

	// per-bit decode step
	always_comb begin
		ph_n    = ph_q;
		cv_n    = cv_q;
		tk_n    = tk_q;
		fi_n    = fi_q;
		rc_n    = rc_q;
		fill_n  = fill_q;
		trk_n   = trk_q;
		fav_we  = 1'b0;
		fav_wd  = flip8(cv_sh);
		run_v   = 1'b0;
		run_val = flip8(cv_sh);
		run_cnt = 9'd1;
		res_v   = 1'b0;
		res     = '0;
		sum     = '0;
		unique case (ph_q)
			PH_HDR: begin
				cv_n = cv_sh;
				tk_n = tk_inc;
				if (tk_inc == 4'd3) begin
					if (cv_sh != 8'd0) begin
						res_v        = 1'b1;
						res.out_kind = KIND_HDR_ERR;
						ph_n         = PH_HALT;
					end
					cv_n = '0;
				end else if (tk_inc >= 4'd11) begin
					res_v         = 1'b1;
					res.out_kind  = KIND_VOLUME;
					res.out_value = flip8(cv_sh);
					cv_n          = '0;
					tk_n          = '0;
					fi_n          = '0;
					ph_n          = PH_FAVS;
				end
			end
			PH_FAVS: begin
				cv_n = cv_sh;
				tk_n = tk_inc;
				if (tk_inc >= 4'd8) begin
					fav_we = 1'b1;
					fi_n   = fi_q + FAV_IDX_W'(1);
					cv_n   = '0;
					tk_n   = '0;
					if (fi_q == FAV_IDX_W'(FAV_COUNT - 1)) begin
						ph_n = PH_SYM;
					end
				end
			end
			PH_SYM: begin
				if (tk_q == 4'd0) begin
					if (!b) begin
						ph_n = PH_LIT;
					end else begin
						tk_n = 4'd1;
						cv_n = '0;
					end
				end else if (tk_q < 4'd7) begin
					cv_n = cv_sh;
					tk_n = tk_inc;
					if (hit) begin
						cv_n    = '0;
						tk_n    = '0;
						run_v   = 1'b1;
						run_val = fav_q[hit_idx];
					end
				end else begin
					// pad bit of the run escape
					cv_n = '0;
					tk_n = '0;
					ph_n = PH_RCHAR;
				end
			end
			PH_LIT: begin
				cv_n = cv_sh;
				tk_n = tk_inc;
				if (tk_inc >= 4'd8) begin
					cv_n  = '0;
					tk_n  = '0;
					ph_n  = PH_SYM;
					run_v = 1'b1;
				end
			end
			PH_RCHAR: begin
				cv_n = cv_sh;
				tk_n = tk_inc;
				if (tk_inc >= 4'd8) begin
					rc_n = flip8(cv_sh);
					cv_n = '0;
					tk_n = '0;
					ph_n = PH_RCOUNT;
				end
			end
			PH_RCOUNT: begin
				cv_n = cv_sh;
				tk_n = tk_inc;
				if (tk_inc >= 4'd8) begin
					cv_n    = '0;
					tk_n    = '0;
					ph_n    = PH_SYM;
					run_v   = 1'b1;
					run_val = rc_q;
					// a zero count stands for a full 256
					run_cnt = (cv_sh == 8'd0) ? 9'd256 : {1'b0, flip8(cv_sh)};
				end
			end
			default: begin
			end
		endcase

		// track accounting for a finished run
		if (run_v) begin
			sum = {1'b0, fill_q} + (FILL_W + 1)'(run_cnt);
			res_v = 1'b1;
			res.out_track = trk_q;
			if (sum > (FILL_W + 1)'(TRACK_BYTES)) begin
				res.out_kind = KIND_OVERRUN;
				ph_n         = PH_HALT;
			end else begin
				res.out_kind  = KIND_RUN;
				res.out_value = run_val;
				res.out_count = run_cnt;
				if (sum == (FILL_W + 1)'(TRACK_BYTES)) begin
					res.out_end_of_track = 1'b1;
					fill_n = '0;
					trk_n  = trk_inc[5:0];
					fi_n   = '0;
					cv_n   = '0;
					tk_n   = '0;
					ph_n   = (trk_inc >= 7'(TRACK_COUNT)) ? PH_HALT : PH_FAVS;
				end else begin
					fill_n = sum[FILL_W-1:0];
				end
			end
		end
	end

	assign step_done = (bit_q == 3'd7) || (ph_n == PH_HALT);

	// result queue write side
	always_comb begin
		of_push = 1'b0;
		of_data = pend_q;
		if (flush_q && !of_full && pend_v_q) begin
			of_push          = 1'b1;
			of_data.out_last = 1'b1;
		end else if (step_en && res_v && pend_v_q) begin
			of_push          = 1'b1;
			of_data.out_last = 1'b0;
		end
	end

	// favourite table
	always_ff @(posedge clk) begin
		if (step_en && fav_we) begin
			fav_q[fi_q] <= fav_wd;
		end
	end

	// byte walker and decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			flush_q  <= 1'b0;
			sh_q     <= '0;
			bit_q    <= '0;
			ph_q     <= PH_HDR;
			cv_q     <= '0;
			tk_q     <= '0;
			fi_q     <= '0;
			rc_q     <= '0;
			fill_q   <= '0;
			trk_q    <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
		end else if (load) begin
			sh_q  <= head.in_byte;
			bit_q <= '0;
			if (head.first) begin
				ph_q   <= PH_HDR;
				cv_q   <= '0;
				tk_q   <= '0;
				fi_q   <= '0;
				rc_q   <= '0;
				fill_q <= '0;
				trk_q  <= '0;
				busy_q <= 1'b1;
			end else begin
				busy_q <= (ph_q != PH_HALT);
			end
		end else if (flush_q) begin
			if (!of_full) begin
				flush_q  <= 1'b0;
				pend_v_q <= 1'b0;
			end
		end else if (step_en) begin
			ph_q   <= ph_n;
			cv_q   <= cv_n;
			tk_q   <= tk_n;
			fi_q   <= fi_n;
			rc_q   <= rc_n;
			fill_q <= fill_n;
			trk_q  <= trk_n;
			sh_q   <= {sh_q[6:0], 1'b0};
			bit_q  <= bit_q + 3'd1;
			if (res_v) begin
				pend_q   <= res;
				pend_v_q <= 1'b1;
			end
			if (step_done) begin
				busy_q  <= 1'b0;
				flush_q <= pend_v_q || res_v;
			end
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (of_push) begin
			of_mem_q[of_wp_q] <= of_data;
		end
	end

	assign empty  = (of_cnt_q == 3'd0);
	assign result = of_mem_q[of_rp_q];
	assign of_pop = pop && !empty;

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			of_wp_q  <= '0;
			of_rp_q  <= '0;
			of_cnt_q <= '0;
		end else begin
			if (of_push) begin
				of_wp_q <= of_wp_q + 2'd1;
			end
			if (of_pop) begin
				of_rp_q <= of_rp_q + 2'd1;
			end
			of_cnt_q <= of_cnt_q + {2'b0, of_push} - {2'b0, of_pop};
		end
	end

endmodule

// ===== rtl/core/ddd_stream_decoder_top.sv =====
// top level of the compressed disk image stream decoder
//
//  channel   dir  handshake         payload
//  input     in   push / full       item   (in_byte, first)
//  results   out  pop / empty       result (kind, value, count, track, eot, last)
//
// a byte is loaded from the input queue, then decoded bit by bit while the result queue has room, and
// when it yields a record, its last record is then flushed to the result queue marked last
// a byte that halts the decoder stops at that bit; a byte ignored while halted is loaded and dropped
// reset is asynchronous; the decoder starts in the header phase
// a full result queue stalls the decoder; the four-entry input queue then fills and raises full
module ddd_stream_decoder_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  ddd_pkg::in_t  item,
	output logic          empty,
	input  logic          pop,
	output ddd_pkg::res_t result
);
	import ddd_pkg::*;

	`include "ddd_stream_decoder_top_defines.svh"

	logic avail;
	in_t  head;
	logic take;
	logic rec_v;
	logic rec_run;
	logic rec_untracked;

	// byte queue
	ddd_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.avail (avail),
		.head  (head),
		.take  (take)
	);

	// decoder and result queue
	ddd_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.avail (avail),
		.head  (head),
		.take  (take),
		.empty (empty),
		.result(result),
		.pop   (pop)
	);

	// record at the result ports and its kind
	assign rec_v         = !empty;
	assign rec_run       = rec_v && result.out_kind == KIND_RUN;
	assign rec_untracked = rec_v &&
		(result.out_kind == KIND_VOLUME || result.out_kind == KIND_HDR_ERR);

	// error records halt the decoder, so they close their byte
	`DDD_ASSERT_SAME(a_err_last, clk, arst_n, rec_v && result.out_kind[1], result.out_last)
	// every run carries a nonzero count
	`DDD_ASSERT_SAME(a_run_count, clk, arst_n, rec_run, result.out_count != 9'd0)
	// volume and header error records belong to no track
	`DDD_ASSERT_SAME(a_hdr_track, clk, arst_n, rec_untracked, {result.out_track, result.out_end_of_track} == 7'd0)

endmodule

// ===== test/ddd_stream_decoder_checker.sv =====
// checker for the stream decoder: predicts every record and compares it with the block
module ddd_stream_decoder_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           full,
	input  ddd_pkg::in_t   item,
	input  logic           empty,
	input  logic           pop,
	input  ddd_pkg::res_t  result,
	output int             fail_count,
	output int             pending
);
	import ddd_pkg::*;

	// decoder state mirrored bit for bit
	phase_t     dec_phase;
	logic [7:0] code_bits;
	int         code_len;
	logic [7:0] fav_byte [FAV_COUNT];
	int         fav_fill;
	logic [7:0] run_byte;
	int         trk_fill;
	int         trk_num;

	res_t record_q [$];
	res_t step_q [$];

	assign pending = record_q.size();

	// back to the state after reset
	function automatic void restart_decode();
		dec_phase = PH_HDR;
		code_bits = '0;
		code_len  = 0;
		fav_fill  = 0;
		run_byte  = '0;
		trk_fill  = 0;
		trk_num   = 0;
	endfunction

	function automatic void add_record(logic [1:0] k, logic [7:0] v, int cnt, int trk,
		logic eot);
		res_t r;
		r.out_kind         = k;
		r.out_value        = v;
		r.out_count        = cnt[8:0];
		r.out_track        = trk[5:0];
		r.out_end_of_track = eot;
		r.out_last         = 1'b0;
		step_q.push_back(r);
	endfunction

	// shift a bit in; true once a whole byte is gathered
	function automatic bit gather_byte(logic b);
		code_bits = {code_bits[6:0], b};
		code_len++;
		return code_len >= 8;
	endfunction

	function automatic void clear_code();
		code_bits = '0;
		code_len  = 0;
	endfunction

	// account for a run, flag an overrun, and close the track when it is full
	function automatic void add_run(logic [7:0] v, int cnt);
		if (trk_fill + cnt > TRACK_BYTES) begin
			add_record(KIND_OVERRUN, 8'd0, 0, trk_num, 1'b0);
			dec_phase = PH_HALT;
			return;
		end
		trk_fill += cnt;
		if (trk_fill >= TRACK_BYTES) begin
			add_record(KIND_RUN, v, cnt, trk_num, 1'b1);
			trk_fill = 0;
			trk_num++;
			fav_fill = 0;
			clear_code();
			dec_phase = (trk_num >= TRACK_COUNT) ? PH_HALT : PH_FAVS;
		end else begin
			add_record(KIND_RUN, v, cnt, trk_num, 1'b0);
		end
	endfunction

	function automatic void decode_bit(logic b);
		logic [7:0] rev;
		bit         hit;
		int         cnt;
		case (dec_phase)
			PH_HDR: begin
				code_bits = {code_bits[6:0], b};
				code_len++;
				if (code_len == 3) begin
					if (code_bits != 0) begin
						add_record(KIND_HDR_ERR, 8'd0, 0, 0, 1'b0);
						dec_phase = PH_HALT;
					end
					code_bits = '0;
				end else if (code_len >= 11) begin
					rev = {<<{code_bits}};
					add_record(KIND_VOLUME, rev, 0, 0, 1'b0);
					clear_code();
					fav_fill  = 0;
					dec_phase = PH_FAVS;
				end
			end
			PH_FAVS: begin
				if (gather_byte(b)) begin
					if (fav_fill < FAV_COUNT) fav_byte[fav_fill] = {<<{code_bits}};
					fav_fill++;
					clear_code();
					if (fav_fill >= FAV_COUNT) dec_phase = PH_SYM;
				end
			end
			PH_SYM: begin
				if (code_len == 0) begin
					if (b == 1'b0) begin
						dec_phase = PH_LIT;
					end else begin
						code_len  = 1;
						code_bits = '0;
					end
				end else if (code_len < 7) begin
					code_bits = {code_bits[6:0], b};
					code_len++;
					hit = 1'b0;
					// a prefix names a favourite only at its own length
					for (int i = 0; i < FAV_COUNT; i++) begin
						if (!hit && code_len == PREFIX_TAKEN[i] && code_bits == PREFIX_CODE[i]) begin
							hit = 1'b1;
							clear_code();
							add_run(fav_byte[i], 1);
						end
					end
				end else begin
					// pad bit of the run escape
					clear_code();
					dec_phase = PH_RCHAR;
				end
			end
			PH_LIT: begin
				if (gather_byte(b)) begin
					rev = {<<{code_bits}};
					clear_code();
					dec_phase = PH_SYM;
					add_run(rev, 1);
				end
			end
			PH_RCHAR: begin
				if (gather_byte(b)) begin
					run_byte  = {<<{code_bits}};
					clear_code();
					dec_phase = PH_RCOUNT;
				end
			end
			PH_RCOUNT: begin
				if (gather_byte(b)) begin
					rev = {<<{code_bits}};
					cnt = (rev == 0) ? 256 : int'(rev);
					clear_code();
					dec_phase = PH_SYM;
					add_run(run_byte, cnt);
				end
			end
			default: ;
		endcase
	endfunction

	// all records caused by one accepted item
	function automatic void decode_item(in_t v);
		if (v.first) restart_decode();
		step_q.delete();
		for (int i = 7; i >= 0; i--) begin
			if (dec_phase != PH_HALT) decode_bit(v.in_byte[i]);
		end
		if (step_q.size() > 0) step_q[step_q.size() - 1].out_last = 1'b1;
		foreach (step_q[i]) record_q.push_back(step_q[i]);
	endfunction

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			restart_decode();
			record_q.delete();
			fail_count <= 0;
		end else begin
			if (pop && !empty) begin
				if (record_q.size() == 0) begin
					$error("result with no record expected: %p", result);
					fail_count <= fail_count + 1;
				end else begin
					e = record_q.pop_front();
					if (e != result) begin
						fail_count <= fail_count + 1;
						if (e.out_kind != result.out_kind)
							$error("out_kind expected %0d got %0d", e.out_kind, result.out_kind);
						if (e.out_value != result.out_value)
							$error("out_value expected %0d got %0d", e.out_value, result.out_value);
						if (e.out_count != result.out_count)
							$error("out_count expected %0d got %0d", e.out_count, result.out_count);
						if (e.out_track != result.out_track)
							$error("out_track expected %0d got %0d", e.out_track, result.out_track);
						if (e.out_end_of_track != result.out_end_of_track)
							$error("out_end_of_track expected %0d got %0d",
								e.out_end_of_track, result.out_end_of_track);
						if (e.out_last != result.out_last)
							$error("out_last expected %0d got %0d", e.out_last, result.out_last);
					end
				end
			end
			if (push && !full) decode_item(item);
		end
	end

endmodule

// ===== test/tb_ddd_stream_decoder_top.sv =====
// testbench top for the stream decoder: builds compressed images and gives the verdict
module tb_ddd_stream_decoder_top;
	import ddd_pkg::*;

	// six bits after the flag that match no prefix at any length
	localparam logic [7:0] ESCAPE_BITS = 8'h34;
	localparam int         QUIET_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_t  item = '0;
	logic empty;
	logic pop = 1'b0;
	res_t result;
	int   fail_count;
	int   pending;

	bit   idle_on = 1'b1;
	int   bytes_sent = 0;
	int   quiet_cycles = 0;
	bit   stream_q [$];

	ddd_stream_decoder_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result)
	);

	ddd_stream_decoder_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(item),
		.empty(empty), .pop(pop), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stalls and one long hold-off that fills the block
	initial begin
		int loops;
		loops = 0;
		@(posedge arst_n);
		forever begin
			loops++;
			if (loops == 400) begin
				pop <= 1'b0;
				repeat (600) @(posedge clk);
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	// offer one item and wait until it is taken
	task automatic send_item(logic [7:0] b, logic f);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		push <= 1'b1;
		item <= '{in_byte: b, first: f};
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	task automatic put_bits(logic [7:0] v, int n);
		for (int i = n - 1; i >= 0; i--) stream_q.push_back(v[i]);
	endtask

	// bytes in the stream are stored low bit first
	task automatic put_rev(logic [7:0] v);
		for (int i = 0; i < 8; i++) stream_q.push_back(v[i]);
	endtask

	task automatic code_literal(logic [7:0] v);
		put_bits(8'd0, 1);
		put_rev(v);
	endtask

	task automatic code_favourite(int idx);
		put_bits(8'd1, 1);
		put_bits(PREFIX_CODE[idx], int'(PREFIX_TAKEN[idx]) - 1);
	endtask

	task automatic code_run(logic [7:0] c, int cnt);
		put_bits(8'd1, 1);
		put_bits(ESCAPE_BITS, 6);
		put_bits(8'($urandom_range(0, 1)), 1);
		put_rev(c);
		put_rev(cnt[7:0]);
	endtask

	task automatic put_header(logic [7:0] vol);
		put_bits(8'd0, 3);
		put_rev(vol);
	endtask

	// tracks of random codes; returns early after a planted overrun
	task automatic put_tracks(int ntr, bit big);
		int fill, rem, pick, cnt;
		for (int t = 0; t < ntr; t++) begin
			for (int i = 0; i < FAV_COUNT; i++) put_rev(8'($urandom()));
			fill = 0;
			while (fill < TRACK_BYTES) begin
				rem  = TRACK_BYTES - fill;
				pick = big ? 9 : $urandom_range(0, 9);
				if (pick < 2) begin
					code_literal(8'($urandom()));
					fill++;
				end else if (pick < 4) begin
					code_favourite($urandom_range(0, FAV_COUNT - 1));
					fill++;
				end else if (!big && rem < 256 && $urandom_range(0, 3) == 0) begin
					code_run(8'($urandom()), $urandom_range(rem + 1, 256));
					return;
				end else begin
					if (rem < 256) cnt = $urandom_range(1, rem);
					else cnt = (big || $urandom_range(0, 3) != 0) ? 256 : $urandom_range(1, 256);
					code_run(8'($urandom()), cnt);
					fill += cnt;
				end
			end
		end
	endtask

	// pack the bit stream into bytes and send it as one image
	task automatic send_stream();
		logic [7:0] b;
		while (stream_q.size() % 8 != 0) stream_q.push_back(1'($urandom_range(0, 1)));
		for (int k = 0; k < stream_q.size(); k += 8) begin
			for (int i = 0; i < 8; i++) b[7 - i] = stream_q[k + i];
			send_item(b, k == 0);
		end
		stream_q.delete();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// header error, then bytes ignored while halted
		send_item(8'h20, 1'b1);
		send_item(8'h55, 1'b0);
		send_item(8'hff, 1'b0);

		// short image with every code kind and field extremes
		put_header(8'hff);
		for (int i = 0; i < FAV_COUNT; i++)
			put_rev((i == 0) ? 8'h00 : (i == FAV_COUNT - 1) ? 8'hff : 8'(i * 13));
		code_literal(8'h00);
		code_literal(8'hff);
		for (int i = 0; i < FAV_COUNT; i++) code_favourite(i);
		code_run(8'hff, 256);
		code_run(8'h00, 1);
		send_stream();

		// random images, some broken, some noise
		while (bytes_sent < 300) begin
			case ($urandom_range(0, 9))
				0: begin
					put_bits(8'($urandom_range(1, 7)), 3);
					put_rev(8'($urandom()));
					send_stream();
				end
				1: begin
					repeat ($urandom_range(1, 12)) put_bits(8'($urandom()), 8);
					send_stream();
				end
				default: begin
					put_header(8'($urandom()));
					put_tracks($urandom_range(1, 2), 1'b0);
					repeat ($urandom_range(0, 3)) put_bits(8'($urandom()), 8);
					send_stream();
				end
			endcase
		end

		// one image of long runs back to back, then a few more bytes
		idle_on = 1'b0;
		put_header(8'h00);
		put_tracks(1, 1'b1);
		repeat (4) put_bits(8'($urandom()), 8);
		send_stream();
		push <= 1'b0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
